FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/bzseq_pkg.sv
// ----------------------------------------------------------------------------
// Buzzer sequencer package
// Types, command codes and the built-in pattern ROM.
// ----------------------------------------------------------------------------
package bzseq_pkg;

   // command codes
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_PLAY  = 2'd1;
   localparam logic [1:0] ACT_STOP  = 2'd2;
   localparam logic [1:0] ACT_TICK  = 2'd3;

   // sound ids
   localparam logic [1:0] SND_SHORT   = 2'd0;
   localparam logic [1:0] SND_CONFIRM = 2'd1;
   localparam logic [1:0] SND_ALARM   = 2'd2;
   localparam logic [1:0] SND_INVALID = 2'd3;

   // buzzer kinds
   localparam logic KIND_ACTIVE  = 1'b0;
   localparam logic KIND_PASSIVE = 1'b1;

   // status codes
   localparam logic STAT_OK      = 1'b0;
   localparam logic STAT_BAD_ARG = 1'b1;

   // register indexes (word address)
   localparam logic [1:0] REG_KIND  = 2'd0;
   localparam logic [1:0] REG_LEVEL = 2'd1;
   localparam logic [1:0] REG_DUTY  = 2'd2;

   localparam int unsigned ADDR_W   = 4;
   localparam int unsigned SEG_IDX_W = 3;
   localparam logic [6:0]  DUTY_RESET = 7'd50;
   localparam logic [6:0]  DUTY_MAX   = 7'd100;
   localparam logic [6:0]  DUTY_MIN   = 7'd1;

   typedef struct packed {
      logic        kind;
      logic        on_level;
      logic [6:0]  duty_percent;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] tone_frequency;
      logic [31:0] tone_duration;
      logic [1:0]  sound_id;
      logic [31:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic        playing;
      logic        pin_level;
      logic        tone_on;
      logic [15:0] tone_frequency_out;
      logic [6:0]  tone_duty;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] freq;
      logic [31:0] len;
   } seg_type;

   // segments per pattern
   function automatic logic [2:0] rom_count(input logic [1:0] sel);
      logic [2:0] n;
      case (sel)
         SND_SHORT:   n = 3'd1;
         SND_CONFIRM: n = 3'd3;
         SND_ALARM:   n = 3'd5;
         default:     n = 3'd0;
      endcase
      return n;
   endfunction

   // pattern ROM; rows past a pattern's end are empty
   function automatic seg_type rom_seg(input logic [1:0] sel,
                                       input logic [SEG_IDX_W-1:0] idx);
      seg_type s;
      s = '{freq: 16'd0, len: 32'd0};
      case (sel)
         SND_SHORT: begin
            case (idx)
               3'd0:    s = '{freq: 16'd2000, len: 32'd80};
               default: s = '{freq: 16'd0, len: 32'd0};
            endcase
         end
         SND_CONFIRM: begin
            case (idx)
               3'd0:    s = '{freq: 16'd1800, len: 32'd100};
               3'd1:    s = '{freq: 16'd0,    len: 32'd80};
               3'd2:    s = '{freq: 16'd2200, len: 32'd120};
               default: s = '{freq: 16'd0, len: 32'd0};
            endcase
         end
         SND_ALARM: begin
            case (idx)
               3'd0:    s = '{freq: 16'd2500, len: 32'd180};
               3'd1:    s = '{freq: 16'd0,    len: 32'd100};
               3'd2:    s = '{freq: 16'd2500, len: 32'd180};
               3'd3:    s = '{freq: 16'd0,    len: 32'd100};
               3'd4:    s = '{freq: 16'd2500, len: 32'd300};
               default: s = '{freq: 16'd0, len: 32'd0};
            endcase
         end
         default: s = '{freq: 16'd0, len: 32'd0};
      endcase
      return s;
   endfunction

endpackage

FILE: design/bzseq_csr.sv
// ----------------------------------------------------------------------------
// Buzzer sequencer register file
// APB-style write/read of buzzer kind, active level and PWM duty.
// ----------------------------------------------------------------------------
module bzseq_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bzseq_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output bzseq_pkg::cfg_type          cfg
);
   import bzseq_pkg::*;

   logic       kind_ff;
   logic       level_ff;
   logic [6:0] duty_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_ACTIVE;
         level_ff <= 1'b1;
         duty_ff  <= DUTY_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_KIND:  kind_ff  <= csr_pwdata[0];
            REG_LEVEL: level_ff <= csr_pwdata[0];
            REG_DUTY:  duty_ff  <= csr_pwdata[6:0];
            default:   ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_KIND:  csr_prdata = {31'd0, kind_ff};
         REG_LEVEL: csr_prdata = {31'd0, level_ff};
         REG_DUTY:  csr_prdata = {25'd0, duty_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   assign cfg = '{kind: kind_ff, on_level: level_ff, duty_percent: duty_ff};

endmodule

FILE: design/bzseq_core.sv
// ----------------------------------------------------------------------------
// Buzzer sequencer core
// Sequencer state and the single-pass command logic that updates it.
// ----------------------------------------------------------------------------
module bzseq_core #(
   parameter int unsigned MAX_SEGMENTS = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  bzseq_pkg::req_item_type item,
   input  bzseq_pkg::cfg_type      cfg,
   output bzseq_pkg::rsp_item_type result
);
   import bzseq_pkg::*;

   localparam logic [3:0] MaxSegW = 4'(MAX_SEGMENTS);

   // sequencer state
   logic                 playing_ff, playing_in;
   logic [31:0]          start_ff, start_in;
   logic [31:0]          len_ff, len_in;
   logic [15:0]          freq_ff, freq_in;
   logic [1:0]           pat_ff, pat_in;
   logic [SEG_IDX_W-1:0] idx_ff, idx_in;
   logic                 pin_ff, pin_in;
   logic                 tone_ff, tone_in;

   logic                 status;
   logic [31:0]          elapsed;
   logic                 expired;
   logic [2:0]           cnt;
   logic [3:0]           plen;
   logic                 more_segs;
   logic                 do_seg;
   logic                 do_stop;
   logic [1:0]           seg_sel;
   logic [SEG_IDX_W-1:0] seg_idx;
   seg_type              seg;
   logic [6:0]           duty;

   // segment timing
   assign elapsed = item.now_ms - start_ff;
   assign expired = playing_ff && (len_ff != 32'd0) && (elapsed >= len_ff);

   // pattern length, cut to MAX_SEGMENTS
   assign cnt       = rom_count(pat_ff - 2'd1);
   assign plen      = (4'(cnt) > MaxSegW) ? MaxSegW : 4'(cnt);
   assign more_segs = (pat_ff != 2'd0) && ((4'(idx_ff) + 4'd1) < plen);

   // command decode and next state
   always_comb begin
      playing_in = playing_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      freq_in    = freq_ff;
      pat_in     = pat_ff;
      idx_in     = idx_ff;
      pin_in     = pin_ff;
      tone_in    = tone_ff;
      status     = STAT_OK;
      do_seg     = 1'b0;
      do_stop    = 1'b0;
      seg_sel    = item.sound_id;
      seg_idx    = '0;

      case (item.action)
         ACT_START: begin
            if (cfg.kind == KIND_PASSIVE && item.tone_frequency == 16'd0) begin
               status = STAT_BAD_ARG;
            end else begin
               if (cfg.kind == KIND_ACTIVE) begin
                  pin_in  = cfg.on_level;
                  freq_in = 16'd0;
               end else begin
                  tone_in = 1'b1;
                  freq_in = item.tone_frequency;
               end
               start_in   = item.now_ms;
               len_in     = item.tone_duration;
               playing_in = 1'b1;
               pat_in     = 2'd0;
               idx_in     = '0;
            end
         end
         ACT_PLAY: begin
            if (item.sound_id == SND_INVALID) begin
               status = STAT_BAD_ARG;
            end else begin
               pat_in  = item.sound_id + 2'd1;
               idx_in  = '0;
               do_seg  = 1'b1;
               seg_sel = item.sound_id;
               seg_idx = '0;
            end
         end
         ACT_STOP: begin
            do_stop = 1'b1;
         end
         default: begin
            // time tick: advance to the next segment or finish
            if (expired) begin
               if (more_segs) begin
                  idx_in  = idx_ff + 1'b1;
                  do_seg  = 1'b1;
                  seg_sel = pat_ff - 2'd1;
                  seg_idx = idx_ff + 1'b1;
               end else begin
                  do_stop = 1'b1;
               end
            end
         end
      endcase

      seg = rom_seg(seg_sel, seg_idx);

      // start a pattern segment; silent ones keep the old frequency
      if (do_seg) begin
         if (seg.freq == 16'd0) begin
            if (cfg.kind == KIND_ACTIVE) pin_in = ~cfg.on_level;
            else tone_in = 1'b0;
         end else if (cfg.kind == KIND_ACTIVE) begin
            pin_in  = cfg.on_level;
            freq_in = 16'd0;
         end else begin
            tone_in = 1'b1;
            freq_in = seg.freq;
         end
         start_in   = item.now_ms;
         len_in     = seg.len;
         playing_in = 1'b1;
      end

      // stop everything
      if (do_stop) begin
         if (cfg.kind == KIND_ACTIVE) pin_in = ~cfg.on_level;
         else tone_in = 1'b0;
         playing_in = 1'b0;
         freq_in    = 16'd0;
         len_in     = 32'd0;
         pat_in     = 2'd0;
         idx_in     = '0;
      end
   end

   // duty clamp to 1..100
   always_comb begin
      duty = cfg.duty_percent;
      if (duty == 7'd0) duty = DUTY_MIN;
      if (duty > DUTY_MAX) duty = DUTY_MAX;
   end

   assign result = '{
      status:             status,
      playing:            playing_in,
      pin_level:          pin_in,
      tone_on:            tone_in,
      tone_frequency_out: tone_in ? freq_in : 16'd0,
      tone_duty:          tone_in ? duty : 7'd0
   };

   // state update, one command per step
   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         start_ff   <= 32'd0;
         len_ff     <= 32'd0;
         freq_ff    <= 16'd0;
         pat_ff     <= 2'd0;
         idx_ff     <= '0;
         pin_ff     <= 1'b0;
         tone_ff    <= 1'b0;
      end else if (step) begin
         playing_ff <= playing_in;
         start_ff   <= start_in;
         len_ff     <= len_in;
         freq_ff    <= freq_in;
         pat_ff     <= pat_in;
         idx_ff     <= idx_in;
         pin_ff     <= pin_in;
         tone_ff    <= tone_in;
      end
   end

endmodule

FILE: design/buzzer_tone_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// Buzzer tone and pattern sequencer
// Stream front end, command core and register port of the buzzer controller.
// ----------------------------------------------------------------------------
// Takes one command beat per clock (start tone, play built-in sound, stop,
// time tick) while results are taken, and returns exactly one result beat
// for each, in order. A beat passes an input register, one pass of command
// logic that also updates the sequencer state, and a result register. While
// a result waits on rsp_tready the input register holds one more beat, then
// req_tready drops until the result is taken.
// Registers (kind, active level, duty) are written through the csr_ port;
// the user must write them only while no command is in flight, which the
// block itself does not enforce. They need no init sequence after reset.
module buzzer_tone_pattern_sequencer #(
   parameter int unsigned MAX_SEGMENTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: tone_frequency[15:0], tone_duration[47:16], sound_id[49:48],
   //        now_ms[81:50], zero[87:82]
   input  logic [87:0] req_tdata,
   // tuser: action[1:0]
   input  logic [1:0]  req_tuser,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: playing[0], pin_level[1], tone_on[2], tone_frequency_out[18:3],
   //        tone_duty[25:19], zero[31:26]
   output logic [31:0] rsp_tdata,
   // tuser: status[0]
   output logic        rsp_tuser,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [bzseq_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bzseq_pkg::*;

   cfg_type      cfg;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         advance;

   bzseq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // move a command into the core when the result slot frees up
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= '{
            action:         req_tuser,
            tone_frequency: req_tdata[15:0],
            tone_duration:  req_tdata[47:16],
            sound_id:       req_tdata[49:48],
            now_ms:         req_tdata[81:50]
         };
      end
   end

   bzseq_core #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.status;
   assign rsp_tdata  = {6'd0, out_item_ff.tone_duty, out_item_ff.tone_frequency_out,
                        out_item_ff.tone_on, out_item_ff.pin_level, out_item_ff.playing};

endmodule

FILE: design/bzseq_checker.sv
// ----------------------------------------------------------------------------
// Buzzer sequencer checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bzseq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // no result beat right after reset
   `ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "result beat after reset")

   // stalled beat holds its payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // tone off shows no frequency and no duty
   `ASSERT_CLK(a_tone_off_quiet, clock, reset, rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[25:3] == 23'd0, "tone data without tone")

   // running tone carries a duty of 1..100
   `ASSERT_CLK(a_duty_range, clock, reset, rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[25:19] != 7'd0 && rsp_tdata[25:19] <= 7'd100, "duty out of range")

endmodule

bind buzzer_tone_pattern_sequencer bzseq_checker u_bzseq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: dv/buzzer_tone_pattern_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buzzer sequencer testbench
// Drives command beats into the sequencer and compares every result beat
// with a cycle-free model of the tone and pattern logic. A short list of
// directed steps comes first, then random phases with register changes.
// ----------------------------------------------------------------------------
module buzzer_tone_pattern_sequencer_test;
   import bzseq_pkg::*;

   localparam int unsigned MAX_SEGS      = 5;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned BLOCK_ITEMS   = 30;
   localparam int unsigned BLOCKS        = 6;
   localparam logic        TYPED         = 1'b1;
   localparam logic        PREDICTED     = 1'b0;

   typedef enum logic {ROW_CMD, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      req_item_type cmd;
      logic         check;
      rsp_item_type want;
      logic [1:0]   reg_idx;
      logic [6:0]   reg_value;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // model of the sequencer: registers and play state
   cfg_type     model_cfg;
   logic        bz_playing;
   logic [31:0] bz_seg_start;
   logic [31:0] bz_seg_len;
   logic [15:0] bz_freq;
   logic [1:0]  bz_pattern;
   logic [2:0]  bz_seg_idx;
   logic        bz_pin;
   logic        bz_tone;

   rsp_item_type pending_results[$];
   step_row_type dir_steps[$];
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;

   buzzer_tone_pattern_sequencer #(
      .MAX_SEGMENTS(MAX_SEGS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // built-in patterns, indexed by sound id and segment
   function automatic seg_type pattern_row(input logic [1:0] snd, input logic [2:0] idx);
      seg_type s;
      s = '0;
      case ({snd, idx})
         {SND_SHORT,   3'd0}: s = {16'd2000, 32'd80};
         {SND_CONFIRM, 3'd0}: s = {16'd1800, 32'd100};
         {SND_CONFIRM, 3'd1}: s = {16'd0,    32'd80};
         {SND_CONFIRM, 3'd2}: s = {16'd2200, 32'd120};
         {SND_ALARM,   3'd0}: s = {16'd2500, 32'd180};
         {SND_ALARM,   3'd1}: s = {16'd0,    32'd100};
         {SND_ALARM,   3'd2}: s = {16'd2500, 32'd180};
         {SND_ALARM,   3'd3}: s = {16'd0,    32'd100};
         {SND_ALARM,   3'd4}: s = {16'd2500, 32'd300};
         default:             s = '0;
      endcase
      return s;
   endfunction

   function automatic int pattern_segments(input logic [1:0] snd);
      int n;
      case (snd)
         SND_SHORT:   n = 1;
         SND_CONFIRM: n = 3;
         SND_ALARM:   n = 5;
         default:     n = 0;
      endcase
      if (n > MAX_SEGS) n = MAX_SEGS;
      return n;
   endfunction

   // silence: inactive pin level or tone off, depending on kind
   function automatic void mute_output();
      if (model_cfg.kind == KIND_ACTIVE) bz_pin = ~model_cfg.on_level;
      else bz_tone = 1'b0;
   endfunction

   function automatic logic play_tone(input logic [15:0] freq, input logic [31:0] len,
                                      input logic [31:0] now);
      if (model_cfg.kind == KIND_ACTIVE) begin
         bz_pin  = model_cfg.on_level;
         bz_freq = 16'd0;
      end else begin
         if (freq == 16'd0) return STAT_BAD_ARG;
         bz_tone = 1'b1;
         bz_freq = freq;
      end
      bz_seg_start = now;
      bz_seg_len   = len;
      bz_playing   = 1'b1;
      return STAT_OK;
   endfunction

   function automatic void load_segment(input logic [31:0] now);
      seg_type s;
      logic    unused_status;
      if (bz_pattern == 2'd0 || bz_seg_idx >= 3'd5) return;
      s = pattern_row(bz_pattern - 2'd1, bz_seg_idx);
      if (s.freq == 16'd0) begin
         mute_output();
         bz_seg_start = now;
         bz_seg_len   = s.len;
         bz_playing   = 1'b1;
      end else begin
         unused_status = play_tone(s.freq, s.len, now);
      end
   endfunction

   function automatic void halt_playback();
      mute_output();
      bz_playing = 1'b0;
      bz_freq    = 16'd0;
      bz_seg_len = 32'd0;
      bz_pattern = 2'd0;
      bz_seg_idx = 3'd0;
   endfunction

   // one command in, the result beat it should produce out
   function automatic rsp_item_type predict_buzzer(input req_item_type c);
      rsp_item_type r;
      logic [31:0]  elapsed;
      logic [6:0]   duty;
      r = '0;
      r.status = STAT_OK;
      elapsed = c.now_ms - bz_seg_start;
      case (c.action)
         ACT_START: begin
            r.status = play_tone(c.tone_frequency, c.tone_duration, c.now_ms);
            if (r.status == STAT_OK) begin
               bz_pattern = 2'd0;
               bz_seg_idx = 3'd0;
            end
         end
         ACT_PLAY: begin
            if (c.sound_id > SND_ALARM) begin
               r.status = STAT_BAD_ARG;
            end else begin
               bz_pattern = c.sound_id + 2'd1;
               bz_seg_idx = 3'd0;
               load_segment(c.now_ms);
            end
         end
         ACT_STOP: halt_playback();
         default: begin
            if (bz_playing && bz_seg_len != 32'd0 && elapsed >= bz_seg_len) begin
               if (bz_pattern != 2'd0 &&
                   int'(bz_seg_idx) + 1 < pattern_segments(bz_pattern - 2'd1)) begin
                  bz_seg_idx = bz_seg_idx + 3'd1;
                  load_segment(c.now_ms);
               end else begin
                  halt_playback();
               end
            end
         end
      endcase
      duty = model_cfg.duty_percent;
      if (duty < DUTY_MIN) duty = DUTY_MIN;
      if (duty > DUTY_MAX) duty = DUTY_MAX;
      r.playing            = bz_playing;
      r.pin_level          = bz_pin;
      r.tone_on            = bz_tone;
      r.tone_frequency_out = bz_tone ? bz_freq : 16'd0;
      r.tone_duty          = bz_tone ? duty : 7'd0;
      return r;
   endfunction

   // readable form of one result beat
   function automatic string rsp_text(input rsp_item_type r);
      return $sformatf("st=%0d play=%0d pin=%0d tone=%0d freq=%0d duty=%0d",
                       r.status, r.playing, r.pin_level, r.tone_on,
                       r.tone_frequency_out, r.tone_duty);
   endfunction

   function automatic void add_cmd(input logic [1:0] act, input logic [15:0] freq,
                                   input logic [31:0] dur, input logic [1:0] snd,
                                   input logic [31:0] now, input logic chk,
                                   input rsp_item_type want);
      step_row_type r;
      r       = '0;
      r.kind  = ROW_CMD;
      r.cmd   = {act, freq, dur, snd, now};
      r.check = chk;
      r.want  = want;
      dir_steps.push_back(r);
   endfunction

   function automatic void add_reg(input logic [1:0] idx, input logic [6:0] value);
      step_row_type r;
      r           = '0;
      r.kind      = ROW_REG;
      r.reg_idx   = idx;
      r.reg_value = value;
      dir_steps.push_back(r);
   endfunction

   task automatic flag_error(input string msg);
      if (error_count < 10) $display("%s", msg);
      error_count++;
   endtask

   // present one command beat, honoring the sender idle rate
   task automatic send_cmd(input req_item_type c, input logic chk, input rsp_item_type want);
      rsp_item_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.action;
      req_tdata  <= {6'd0, c.now_ms, c.sound_id, c.tone_duration, c.tone_frequency};
      do @(posedge clock); while (!req_tready);
      pred = predict_buzzer(c);
      pending_results.push_back(chk ? want : pred);
   endtask

   // stop sending and wait until every expected beat has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register bus transfer: setup, access, then a bus idle cycle
   task automatic csr_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write a register, mirror it in the model and read it back
   task automatic program_reg(input logic [1:0] idx, input logic [6:0] value);
      logic [31:0] rd;
      logic [31:0] want;
      csr_access(1'b1, idx, {25'd0, value}, rd);
      case (idx)
         REG_KIND: begin
            model_cfg.kind = value[0];
            want = {31'd0, value[0]};
         end
         REG_LEVEL: begin
            model_cfg.on_level = value[0];
            want = {31'd0, value[0]};
         end
         default: begin
            model_cfg.duty_percent = value;
            want = {25'd0, value};
         end
      endcase
      csr_access(1'b0, idx, 32'd0, rd);
      if (rd !== want)
         flag_error($sformatf("register %0d readback: expected %0h, got %0h", idx, want, rd));
   endtask

   // receiver stalls
   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // result checker
   always @(posedge clock) begin : result_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[0], rsp_tdata[1], rsp_tdata[2],
                rsp_tdata[18:3], rsp_tdata[25:19]};
         if (pending_results.size() == 0) begin
            flag_error("result beat with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.playing !== want.playing ||
                got.pin_level !== want.pin_level || got.tone_on !== want.tone_on ||
                got.tone_frequency_out !== want.tone_frequency_out ||
                got.tone_duty !== want.tone_duty)
               flag_error($sformatf("result mismatch: expected %s, got %s",
                                    rsp_text(want), rsp_text(got)));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      step_row_type row;
      req_item_type c;
      logic [31:0]  t_ms;
      int unsigned  roll;
      logic [6:0]   duty;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      // model state after reset
      model_cfg    = '{kind: KIND_ACTIVE, on_level: 1'b1, duty_percent: DUTY_RESET};
      bz_playing   = 1'b0;
      bz_seg_start = 32'd0;
      bz_seg_len   = 32'd0;
      bz_freq      = 16'd0;
      bz_pattern   = 2'd0;
      bz_seg_idx   = 3'd0;
      bz_pin       = 1'b0;
      bz_tone      = 1'b0;

      send_idle_pct = 11;
      recv_idle_pct = 66;

      // directed steps: reset state, field extremes, every command, error paths
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd0, TYPED, {STAT_OK, 3'b000, 16'd0, 7'd0});
      add_cmd(ACT_START, 16'hFFFF, 32'd0, SND_SHORT, 32'd0, TYPED,
              {STAT_OK, 3'b110, 16'd0, 7'd0});
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'hFFFF_FFFF, PREDICTED, '0);
      add_cmd(ACT_PLAY, 16'd0, 32'd0, SND_INVALID, 32'd0, TYPED,
              {STAT_BAD_ARG, 3'b110, 16'd0, 7'd0});
      add_cmd(ACT_STOP, 16'hFFFF, 32'hFFFF_FFFF, SND_INVALID, 32'hFFFF_FFFF, TYPED,
              {STAT_OK, 3'b000, 16'd0, 7'd0});
      // short beep straddling the millisecond wrap
      add_cmd(ACT_PLAY, 16'd0, 32'd0, SND_SHORT, 32'hFFFF_FFF0, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'h0000_003F, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'h0000_0040, PREDICTED, '0);
      // confirm pattern through its silent gap
      add_cmd(ACT_PLAY, 16'd0, 32'd0, SND_CONFIRM, 32'd1000, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd1100, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd1180, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd1300, PREDICTED, '0);
      // active start ignores the frequency; longest duration runs out across the wrap
      add_cmd(ACT_START, 16'd0, 32'hFFFF_FFFF, SND_SHORT, 32'd5, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd4, PREDICTED, '0);
      // passive with duty below range, zero frequency rejected
      add_reg(REG_KIND, {6'd0, KIND_PASSIVE});
      add_reg(REG_DUTY, 7'd0);
      add_cmd(ACT_START, 16'd0, 32'd10, SND_SHORT, 32'd100, TYPED,
              {STAT_BAD_ARG, 3'b000, 16'd0, 7'd0});
      add_cmd(ACT_START, 16'hFFFF, 32'd10, SND_SHORT, 32'd100, TYPED,
              {STAT_OK, 3'b101, 16'hFFFF, DUTY_MIN});
      // alarm pattern with duty above range, played to its end
      add_reg(REG_DUTY, 7'd127);
      add_cmd(ACT_PLAY, 16'd0, 32'd0, SND_ALARM, 32'd0, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd180, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd280, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd460, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd560, PREDICTED, '0);
      add_cmd(ACT_TICK, 16'd0, 32'd0, SND_SHORT, 32'd860, PREDICTED, '0);
      // active buzzer sounding on a low pin
      add_reg(REG_LEVEL, 7'd0);
      add_reg(REG_KIND, {6'd0, KIND_ACTIVE});
      add_reg(REG_DUTY, DUTY_MAX);
      add_cmd(ACT_PLAY, 16'd0, 32'd0, SND_SHORT, 32'd7, PREDICTED, '0);
      add_cmd(ACT_STOP, 16'd0, 32'd0, SND_SHORT, 32'd9, PREDICTED, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_steps[i]) begin
         row = dir_steps[i];
         if (row.kind == ROW_REG) begin
            drain();
            program_reg(row.reg_idx, row.reg_value);
         end else begin
            send_cmd(row.cmd, row.check, row.want);
         end
      end

      // random phases: receiver idle heavy, then sender idle heavy, then none
      t_ms = 32'd0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 66 : 0;
         recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 11 : 0;
         for (int b = 0; b < BLOCKS; b++) begin
            // new register setting; playback state carries over
            case (b)
               0:       duty = 7'd0;
               1:       duty = 7'd127;
               2:       duty = DUTY_MAX;
               3:       duty = DUTY_MIN;
               default: duty = 7'($urandom_range(0, 127));
            endcase
            drain();
            program_reg(REG_KIND, 7'((b + ph) % 2));
            program_reg(REG_LEVEL, 7'($urandom_range(0, 1)));
            program_reg(REG_DUTY, duty);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
               c.action         = 2'($urandom);
               c.tone_frequency = 16'($urandom);
               c.tone_duration  = $urandom;
               c.sound_id       = 2'($urandom);
               c.now_ms         = $urandom;
               roll = $urandom_range(0, 99);
               // most beats follow a running millisecond count; the rest are noise
               if (roll >= 8) begin
                  t_ms = t_ms + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                             : $urandom_range(0, 120));
                  if ($urandom_range(0, 199) == 0) t_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
                  c.now_ms = t_ms;
                  if (roll < 60) begin
                     c.action = ACT_TICK;
                  end else if (roll < 80) begin
                     c.action   = ACT_PLAY;
                     c.sound_id = ($urandom_range(0, 9) == 0) ? SND_INVALID
                                                               : 2'($urandom_range(0, 2));
                  end else if (roll < 93) begin
                     c.action = ACT_START;
                     case ($urandom_range(0, 7))
                        0:       c.tone_frequency = 16'd0;
                        1:       c.tone_frequency = 16'($urandom);
                        default: c.tone_frequency = 16'($urandom_range(1, 4000));
                     endcase
                     case ($urandom_range(0, 15))
                        0, 1:    c.tone_duration = 32'd0;
                        2:       c.tone_duration = $urandom;
                        default: c.tone_duration = $urandom_range(1, 300);
                     endcase
                  end else begin
                     c.action = ACT_STOP;
                  end
               end
               send_cmd(c, PREDICTED, '0);
            end
         end
      end

      drain();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
